// File: src/sgg_pkg.sv
// ----------------------------------------------------------------------------
// sgg_pkg
// Shared types and constants for the staggered grid gradient correction block.
// ----------------------------------------------------------------------------
package sgg_pkg;

  // Field and register widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned COORD_W   = 4;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;

  // Stencil: eight corners, tag bit 2 = previous x, 1 = previous y, 0 = previous z
  localparam int unsigned CORNER_W    = 3;
  localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

  // Arithmetic widths: difference of two four-cell sums fits 35 bits signed,
  // its magnitude 34 bits; magnitude times a 16-bit half of the step is 50 bits.
  localparam int unsigned DIFF_W  = 35;
  localparam int unsigned MAG_W   = DIFF_W - 1;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned PROD_W  = MAG_W + HALF_W;
  localparam int unsigned CORR_W  = PROD_W - 1;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned RND_SHIFT = 18;
  localparam logic [SUM_W-1:0] RND_BIAS = SUM_W'(1) << (RND_SHIFT - 1);

  // Back-end pipeline depth
  localparam int unsigned STAGES = 4;

  // Register reset values
  localparam logic [COUNT_W-1:0] CELLS_RESET = 5'd16;
  localparam logic [DATA_W-1:0]  STEP_RESET  = 32'h0001_0000;

  // Saturation limits
  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_CORRECT = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELLS_X    = 3'd0,
    CFG_CELLS_Y    = 3'd1,
    CFG_CELLS_Z    = 3'd2,
    CFG_INV_STEP_X = 3'd3,
    CFG_INV_STEP_Y = 3'd4,
    CFG_INV_STEP_Z = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_WAIT = 2'd2
  } fetch_state_e;

  typedef struct packed {
    logic [COUNT_W-1:0] cells_x;
    logic [COUNT_W-1:0] cells_y;
    logic [COUNT_W-1:0] cells_z;
  } grid_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] inv_step_x;
    logic [DATA_W-1:0] inv_step_y;
    logic [DATA_W-1:0] inv_step_z;
  } step_cfg_t;

  // Request from the grid fetch to the arithmetic pipeline
  typedef struct packed {
    logic signed [DIFF_W-1:0] d_x;
    logic signed [DIFF_W-1:0] d_y;
    logic signed [DIFF_W-1:0] d_z;
    logic signed [DATA_W-1:0] f_x;
    logic signed [DATA_W-1:0] f_y;
    logic signed [DATA_W-1:0] f_z;
  } fe_item_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// File: src/sgg_fetch.sv
// ----------------------------------------------------------------------------
// sgg_fetch
// Potential grid memory and stencil sequencer: writes loads, reads the eight
// corners of a correct request and accumulates the three differences.
// ----------------------------------------------------------------------------
module sgg_fetch
  import sgg_pkg::*;
#(
  parameter int MAX_CELLS_X = 16,
  parameter int MAX_CELLS_Y = 16,
  parameter int MAX_CELLS_Z = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     command_i,
  input  logic [COORD_W-1:0]       cell_x_i,
  input  logic [COORD_W-1:0]       cell_y_i,
  input  logic [COORD_W-1:0]       cell_z_i,
  input  logic signed [DATA_W-1:0] potential_i,
  input  logic signed [DATA_W-1:0] field_x_in_i,
  input  logic signed [DATA_W-1:0] field_y_in_i,
  input  logic signed [DATA_W-1:0] field_z_in_i,
  input  grid_cfg_t                grid_i,
  output logic                     item_valid_o,
  input  logic                     item_ready_i,
  output fe_item_t                 item_o
);

  localparam int DEPTH  = MAX_CELLS_X * MAX_CELLS_Y * MAX_CELLS_Z;
  localparam int ADDR_W = $clog2(DEPTH);

  function automatic logic [ADDR_W-1:0] grid_addr(input logic [COUNT_W-1:0] x,
                                                  input logic [COUNT_W-1:0] y,
                                                  input logic [COUNT_W-1:0] z);
    grid_addr = ADDR_W'(int'(x) * MAX_CELLS_Y * MAX_CELLS_Z
                        + int'(y) * MAX_CELLS_Z + int'(z));
  endfunction

  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] n,
                                                   input int max_n);
    if (n == '0) eff_count = COUNT_W'(1);
    else if (int'(n) > max_n) eff_count = COUNT_W'(max_n);
    else eff_count = n;
  endfunction

  fetch_state_e state_q, state_d;
  logic [CORNER_W-1:0] cnt_q, cnt_d;
  logic item_vld_q, item_vld_d;
  logic rd_vld_q, rd_vld_d;
  logic [CORNER_W-1:0] rd_tag_q, rd_tag_d;
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] mem_q [DEPTH];

  logic signed [DIFF_W-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d, acc_z_q, acc_z_d;
  logic signed [DATA_W-1:0] fx_q, fx_d, fy_q, fy_d, fz_q, fz_d;
  logic [COUNT_W-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [COUNT_W-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;

  logic [COUNT_W-1:0] nx, ny, nz;
  logic [COUNT_W-1:0] ix, iy, iz;
  logic in_grid, accept;
  logic mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic signed [DIFF_W-1:0] rd_ext;

  // Effective extents and the addressed cell
  always_comb begin
    nx = eff_count(grid_i.cells_x, MAX_CELLS_X);
    ny = eff_count(grid_i.cells_y, MAX_CELLS_Y);
    nz = eff_count(grid_i.cells_z, MAX_CELLS_Z);
    ix = {1'b0, cell_x_i};
    iy = {1'b0, cell_y_i};
    iz = {1'b0, cell_z_i};
    in_grid = (ix < nx) && (iy < ny) && (iz < nz);
  end

  assign in_stall_o = (state_q != ST_IDLE) || (item_vld_q && !item_ready_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign rd_ext     = DIFF_W'($signed(rd_q));

  // Sequencer: next state, memory port and accumulators
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    item_vld_d = item_vld_q && !item_ready_i;
    rd_vld_d   = 1'b0;
    rd_tag_d   = cnt_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = grid_addr(cnt_q[2] ? px_q : cx_q,
                           cnt_q[1] ? py_q : cy_q,
                           cnt_q[0] ? pz_q : cz_q);
    fx_d = fx_q;  fy_d = fy_q;  fz_d = fz_q;
    cx_d = cx_q;  cy_d = cy_q;  cz_d = cz_q;
    px_d = px_q;  py_d = py_q;  pz_d = pz_q;

    // corner on own index adds, corner on previous index subtracts
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    acc_z_d = acc_z_q;
    if (rd_vld_q) begin
      acc_x_d = rd_tag_q[2] ? acc_x_q - rd_ext : acc_x_q + rd_ext;
      acc_y_d = rd_tag_q[1] ? acc_y_q - rd_ext : acc_y_q + rd_ext;
      acc_z_d = rd_tag_q[0] ? acc_z_q - rd_ext : acc_z_q + rd_ext;
    end

    case (state_q)
      ST_IDLE: begin
        mem_addr = grid_addr(ix, iy, iz);
        if (accept) begin
          if (command_i == CMD_LOAD) begin
            mem_we = in_grid;
          end else begin
            fx_d = field_x_in_i;
            fy_d = field_y_in_i;
            fz_d = field_z_in_i;
            acc_x_d = '0;
            acc_y_d = '0;
            acc_z_d = '0;
            if (in_grid) begin
              // own corner is read right away
              mem_re   = 1'b1;
              rd_vld_d = 1'b1;
              rd_tag_d = '0;
              cx_d = ix;  cy_d = iy;  cz_d = iz;
              px_d = (ix == '0) ? nx - COUNT_W'(1) : ix - COUNT_W'(1);
              py_d = (iy == '0) ? ny - COUNT_W'(1) : iy - COUNT_W'(1);
              pz_d = (iz == '0) ? nz - COUNT_W'(1) : iz - COUNT_W'(1);
              cnt_d   = CORNER_W'(1);
              state_d = ST_READ;
            end else begin
              // outside the grid: zero differences pass the field through
              item_vld_d = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        mem_re   = 1'b1;
        rd_vld_d = 1'b1;
        cnt_d    = cnt_q + CORNER_W'(1);
        if (cnt_q == LAST_CORNER) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        // last corner is folded in this cycle
        item_vld_d = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      item_vld_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_tag_q   <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      item_vld_q <= item_vld_d;
      rd_vld_q   <= rd_vld_d;
      rd_tag_q   <= rd_tag_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    acc_x_q <= acc_x_d;  acc_y_q <= acc_y_d;  acc_z_q <= acc_z_d;
    fx_q <= fx_d;  fy_q <= fy_d;  fz_q <= fz_d;
    cx_q <= cx_d;  cy_q <= cy_d;  cz_q <= cz_d;
    px_q <= px_d;  py_q <= py_d;  pz_q <= pz_d;
  end

  // Single-port grid memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= potential_i;
    if (mem_re) rd_q <= mem_q[mem_addr];
  end

  assign item_valid_o = item_vld_q;
  assign item_o = '{d_x: acc_x_q, d_y: acc_y_q, d_z: acc_z_q,
                    f_x: fx_q, f_y: fy_q, f_z: fz_q};

endmodule

// File: src/sgg_lane.sv
// ----------------------------------------------------------------------------
// sgg_lane
// One gradient component: magnitude, split multiply by the reciprocal
// spacing, rounding by a quarter, then saturating add to the field.
// ----------------------------------------------------------------------------
module sgg_lane
  import sgg_pkg::*;
(
  input  logic                     clk_i,
  input  stage_en_t                en_i,
  input  logic signed [DIFF_W-1:0] d_i,
  input  logic signed [DATA_W-1:0] f_i,
  input  logic [DATA_W-1:0]        step_i,
  output logic signed [DATA_W-1:0] field_o,
  output logic                     clip_o
);

  logic                     neg1_q, neg2_q, neg3_q;
  logic [MAG_W-1:0]         mag1_q;
  logic [PROD_W-1:0]        pa2_q, pb2_q;
  logic [CORR_W-1:0]        r3_q;
  logic signed [DATA_W-1:0] f1_q, f2_q, f3_q;
  logic signed [DATA_W-1:0] field_q;
  logic                     clip_q;

  logic signed [DIFF_W-1:0] d_abs;
  logic [PROD_W-1:0]        pa_c, pb_c;
  logic [SUM_W-1:0]         low_c;
  logic [CORR_W-1:0]        r_c;
  logic signed [SUM_W-1:0]  f_ext, corr_c, sum_c;
  logic                     over_c, under_c;

  // stage 1: magnitude
  assign d_abs = d_i[DIFF_W-1] ? -d_i : d_i;

  // stage 2: two 34x16 partial products
  assign pa_c = mag1_q * step_i[DATA_W-1:HALF_W];
  assign pb_c = mag1_q * step_i[HALF_W-1:0];

  // stage 3: shift by 18 with round half away from zero on the magnitude
  assign low_c = SUM_W'({pa2_q[1:0], {HALF_W{1'b0}}}) + SUM_W'(pb2_q) + RND_BIAS;
  assign r_c   = CORR_W'(pa2_q >> 2) + CORR_W'(low_c >> RND_SHIFT);

  // stage 4: correction is minus sign(d) times the magnitude
  assign f_ext   = SUM_W'(f3_q);
  assign corr_c  = neg3_q ? $signed({2'b00, r3_q}) : -$signed({2'b00, r3_q});
  assign sum_c   = f_ext + corr_c;
  assign over_c  = !sum_c[SUM_W-1] && (sum_c[SUM_W-2:DATA_W-1] != '0);
  assign under_c = sum_c[SUM_W-1] && (sum_c[SUM_W-2:DATA_W-1] != '1);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      neg1_q <= d_i[DIFF_W-1];
      mag1_q <= MAG_W'(d_abs);
      f1_q   <= f_i;
    end
    if (en_i.s2) begin
      neg2_q <= neg1_q;
      pa2_q  <= pa_c;
      pb2_q  <= pb_c;
      f2_q   <= f1_q;
    end
    if (en_i.s3) begin
      neg3_q <= neg2_q;
      r3_q   <= r_c;
      f3_q   <= f2_q;
    end
    if (en_i.s4) begin
      if (over_c)       field_q <= SAT_POS;
      else if (under_c) field_q <= SAT_NEG;
      else              field_q <= sum_c[DATA_W-1:0];
      clip_q <= over_c || under_c;
    end
  end

  assign field_o = field_q;
  assign clip_o  = clip_q;

endmodule

// File: src/sgg_pipe.sv
// ----------------------------------------------------------------------------
// sgg_pipe
// Four-stage arithmetic pipeline for the three components with a valid bit
// per stage and bubble-collapsing stall.
// ----------------------------------------------------------------------------
module sgg_pipe
  import sgg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  fe_item_t                 item_i,
  input  step_cfg_t                steps_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] field_x_o,
  output logic signed [DATA_W-1:0] field_y_o,
  output logic signed [DATA_W-1:0] field_z_o,
  output logic                     saturated_o
);

  logic [STAGES-1:0] vld_q, vld_d;
  logic [STAGES:0]   rdy;
  stage_en_t         en;
  logic              clip_x, clip_y, clip_z;

  // a stage loads when empty or when the one after it moves
  always_comb begin
    rdy[STAGES] = !out_stall_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3]};

  sgg_lane u_lane_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .d_i     (item_i.d_x),
    .f_i     (item_i.f_x),
    .step_i  (steps_i.inv_step_x),
    .field_o (field_x_o),
    .clip_o  (clip_x)
  );

  sgg_lane u_lane_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .d_i     (item_i.d_y),
    .f_i     (item_i.f_y),
    .step_i  (steps_i.inv_step_y),
    .field_o (field_y_o),
    .clip_o  (clip_y)
  );

  sgg_lane u_lane_z (
    .clk_i   (clk_i),
    .en_i    (en),
    .d_i     (item_i.d_z),
    .f_i     (item_i.f_z),
    .step_i  (steps_i.inv_step_z),
    .field_o (field_z_o),
    .clip_o  (clip_z)
  );

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[STAGES-1];
  assign saturated_o = clip_x || clip_y || clip_z;

endmodule

// File: src/staggered_grid_gradient_correct.sv
// ----------------------------------------------------------------------------
// staggered_grid_gradient_correct
// Periodic 3D grid of a correction potential; adds the minus staggered
// gradient of the potential to a field vector, Q16.16 with saturation.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  request  | in_valid_i/in_stall_o | command, cell xyz, potential, field in
//  result   | out_valid_o/out_stall_i | field out xyz, saturated
//  config   | cfg_we_i             | cfg_idx_i, cfg_data_i
//
//  A load request does not hold the request side; a correct request inside
//  the grid holds it for the eight corner reads through the single grid
//  memory port plus the wait for the last read. Outside the grid it does not.
//  Results pass the fetch output register, then the pipeline stages.
//  Reset restores the register defaults and empties the pipeline; the grid
//  memory is not cleared. A stalled result holds the pipeline in place while
//  empty stages still fill.
// ----------------------------------------------------------------------------
module staggered_grid_gradient_correct
  import sgg_pkg::*;
#(
  parameter int MAX_CELLS_X = 16,
  parameter int MAX_CELLS_Y = 16,
  parameter int MAX_CELLS_Z = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     command_i,
  input  logic [COORD_W-1:0]       cell_x_i,
  input  logic [COORD_W-1:0]       cell_y_i,
  input  logic [COORD_W-1:0]       cell_z_i,
  input  logic signed [DATA_W-1:0] potential_i,
  input  logic signed [DATA_W-1:0] field_x_in_i,
  input  logic signed [DATA_W-1:0] field_y_in_i,
  input  logic signed [DATA_W-1:0] field_z_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] field_x_out_o,
  output logic signed [DATA_W-1:0] field_y_out_o,
  output logic signed [DATA_W-1:0] field_z_out_o,
  output logic                     saturated_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_data_i
);

  grid_cfg_t grid_q;
  step_cfg_t steps_q;
  logic      fe_valid, fe_ready;
  fe_item_t  fe_item;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q  <= '{cells_x: CELLS_RESET, cells_y: CELLS_RESET, cells_z: CELLS_RESET};
      steps_q <= '{inv_step_x: STEP_RESET, inv_step_y: STEP_RESET,
                   inv_step_z: STEP_RESET};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CELLS_X:    grid_q.cells_x     <= cfg_data_i[COUNT_W-1:0];
        CFG_CELLS_Y:    grid_q.cells_y     <= cfg_data_i[COUNT_W-1:0];
        CFG_CELLS_Z:    grid_q.cells_z     <= cfg_data_i[COUNT_W-1:0];
        CFG_INV_STEP_X: steps_q.inv_step_x <= cfg_data_i;
        CFG_INV_STEP_Y: steps_q.inv_step_y <= cfg_data_i;
        CFG_INV_STEP_Z: steps_q.inv_step_z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sgg_fetch #(
    .MAX_CELLS_X (MAX_CELLS_X),
    .MAX_CELLS_Y (MAX_CELLS_Y),
    .MAX_CELLS_Z (MAX_CELLS_Z)
  ) u_fetch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_z_i     (cell_z_i),
    .potential_i  (potential_i),
    .field_x_in_i (field_x_in_i),
    .field_y_in_i (field_y_in_i),
    .field_z_in_i (field_z_in_i),
    .grid_i       (grid_q),
    .item_valid_o (fe_valid),
    .item_ready_i (fe_ready),
    .item_o       (fe_item)
  );

  sgg_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fe_valid),
    .in_ready_o  (fe_ready),
    .item_i      (fe_item),
    .steps_i     (steps_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .field_x_o   (field_x_out_o),
    .field_y_o   (field_y_out_o),
    .field_z_o   (field_z_out_o),
    .saturated_o (saturated_o)
  );

  // A fetched request waits intact until the pipeline takes it
  a_fe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_valid && !fe_ready |=> fe_valid && $stable(fe_item))
    else $error("fetch request changed while waiting");

  // A fetched request appears only after a correct request or a busy fetch
  a_fe_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fe_valid) |-> $past(in_stall_o)
      || $past(in_valid_i && command_i == CMD_CORRECT))
    else $error("fetch request without a source");

  // An accepted correct request either occupies the fetch or is handed on
  a_correct_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && command_i == CMD_CORRECT |=> in_stall_o || fe_valid)
    else $error("correct request dropped");

endmodule
